// ===== rtl/dpw_sawtooth_oscillator_top_macros.svh =====
// Assertion macros shared by the oscillator RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DPW_SAWTOOTH_OSCILLATOR_TOP_MACROS_SVH
`define DPW_SAWTOOTH_OSCILLATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPW_SAW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPW_SAW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dpw_saw_pkg.sv =====
package dpw_saw_pkg;

  // Width of the phase accumulator.
  localparam int PHASE_BITS = 32;

  // Fixed widths of the arithmetic.
  localparam int FRAC_W   = 32;
  localparam int SQ_W     = 33;
  localparam int CU_W     = 33;
  localparam int CUBIC_W  = 32;
  localparam int D1_W     = 33;
  localparam int SAMPLE_W = 34;
  localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int IN_TDATA_W  = ((FRAC_W + 7) / 8) * 8;

  // Shifts that align a 32-bit fraction to the phase width and back.
  localparam int ALIGN_SHL = (PHASE_BITS >= FRAC_W) ? PHASE_BITS - FRAC_W : 0;
  localparam int ALIGN_SHR = (PHASE_BITS < FRAC_W) ? FRAC_W - PHASE_BITS : 0;

  // Offset that maps phase [0,1) to x in [-1,1).
  localparam logic [FRAC_W-1:0] X_OFFSET = {1'b1, {(FRAC_W-1){1'b0}}};

  // Item kinds carried in tuser.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef logic [PHASE_BITS-1:0] phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // load the phase from the input item
    logic advance;  // add the increment to the phase
    logic sq_en;    // register x*x
    logic cu_en;    // register sq*x
    logic commit;   // update the delays and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // output register can take a result this cycle
  } status_t;

  // Align a signed fraction (units of 2^-32) to the phase width, floor on right shift.
  function automatic phase_t align_frac(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = (v <<< ALIGN_SHL) >>> ALIGN_SHR;
    return s[PHASE_BITS-1:0];
  endfunction

  // Top 32 bits of the phase.
  function automatic logic [FRAC_W-1:0] top_frac(input phase_t ph);
    logic [63:0] w;
    w = (64'(ph) >> ALIGN_SHL) << ALIGN_SHR;
    return w[FRAC_W-1:0];
  endfunction

endpackage

// ===== rtl/dpw_saw_ctrl.sv =====
module dpw_saw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  input  dpw_saw_pkg::status_t status_i,
  output dpw_saw_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_CU   = 4'b0100,
    ST_DIFF = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Sequencing of loads, and of one tick through the two multiplies and the differences.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == dpw_saw_pkg::CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d     = ST_CU;
      end
      ST_CU: begin
        cmd_o.cu_en = 1'b1;
        state_d     = ST_DIFF;
      end
      ST_DIFF: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/dpw_saw_dp.sv =====
module dpw_saw_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dpw_saw_pkg::FRAC_W-1:0]         cfg_wdata_i,
  input  logic [dpw_saw_pkg::FRAC_W-1:0]         new_phase_i,
  input  dpw_saw_pkg::cmd_t                      cmd_i,
  output dpw_saw_pkg::status_t                   status_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [dpw_saw_pkg::SAMPLE_W-1:0] sample_o
);

  logic [dpw_saw_pkg::FRAC_W-1:0]          inc_q;
  dpw_saw_pkg::phase_t                     phase_q, phase_d;
  logic signed [dpw_saw_pkg::SQ_W-1:0]     sq_q;
  logic signed [dpw_saw_pkg::CU_W-1:0]     cu_q;
  logic signed [dpw_saw_pkg::CUBIC_W-1:0]  prev_c_q;
  logic signed [dpw_saw_pkg::D1_W-1:0]     prev_d1_q;
  logic signed [dpw_saw_pkg::SAMPLE_W-1:0] out_q;
  logic                                    out_valid_q;

  logic signed [dpw_saw_pkg::FRAC_W-1:0]    x;
  logic signed [2*dpw_saw_pkg::FRAC_W-1:0]  sq_prod;
  logic signed [dpw_saw_pkg::SQ_W+dpw_saw_pkg::FRAC_W-1:0] cu_prod;
  logic signed [dpw_saw_pkg::SAMPLE_W-1:0]  c_wide;
  logic signed [dpw_saw_pkg::CUBIC_W-1:0]   c;
  logic signed [dpw_saw_pkg::D1_W-1:0]      d1;
  logic signed [dpw_saw_pkg::SAMPLE_W-1:0]  d2;

  // Increment register, reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q <= '0;
    end else if (cfg_we_i) begin
      inc_q <= cfg_wdata_i;
    end
  end

  // Phase accumulator: load or wrapping advance.
  always_comb begin
    phase_d = phase_q;
    if (cmd_i.load) begin
      phase_d = dpw_saw_pkg::align_frac(signed'(64'(new_phase_i)));
    end else if (cmd_i.advance) begin
      phase_d = phase_q + dpw_saw_pkg::align_frac(64'(signed'(inc_q)));
    end
  end

  // x = phase mapped to [-1,1) in Q1.31.
  assign x = signed'(dpw_saw_pkg::top_frac(phase_q) ^ dpw_saw_pkg::X_OFFSET);

  // First multiply: x*x, floored to Q2.31 (the product's low bits drop).
  assign sq_prod = x * x;

  // Second multiply: sq*x, floored to Q2.31.
  assign cu_prod = sq_q * x;

  // Cubic and the two backward differences.
  assign c_wide = dpw_saw_pkg::SAMPLE_W'(cu_q) - dpw_saw_pkg::SAMPLE_W'(x);
  assign c      = c_wide[dpw_saw_pkg::CUBIC_W-1:0];
  assign d1     = dpw_saw_pkg::D1_W'(c) - dpw_saw_pkg::D1_W'(prev_c_q);
  assign d2     = dpw_saw_pkg::SAMPLE_W'(d1) - dpw_saw_pkg::SAMPLE_W'(prev_d1_q);

  // Phase and difference delays, zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      prev_c_q  <= '0;
      prev_d1_q <= '0;
    end else begin
      phase_q <= phase_d;
      if (cmd_i.commit) begin
        prev_c_q  <= c;
        prev_d1_q <= d1;
      end
    end
  end

  // Multiplier result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sq_q <= sq_prod[2*dpw_saw_pkg::FRAC_W-1:dpw_saw_pkg::FRAC_W-1];
    end
    if (cmd_i.cu_en) begin
      cu_q <= cu_prod[2*dpw_saw_pkg::FRAC_W-1:dpw_saw_pkg::FRAC_W-1];
    end
  end

  // Output register: holds one sample until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= d2;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_o          = out_q;

endmodule

// ===== rtl/dpw_sawtooth_oscillator_top.sv =====
// Cubic DPW sawtooth oscillator.
// Input stream (s_axis): each item is a tick (tuser = 0) or a phase load
// (tuser = 1, phase in tdata). A tick produces one sample; a load produces none.
// Output stream (m_axis): one signed 34-bit sample per tick, in units of 2^-31.
// Configuration: cfg_we_i writes the signed phase increment from cfg_wdata_i.
// Write it only while no tick is in flight.
// Sequencing: an accepted tick then passes the x*x multiply, the sq*x
// multiply and the differences steps, and its sample is registered in the
// output register when the differences step commits. No new item is accepted
// until the tick has passed these steps, as the two multiplies run in sequence.
// A load is taken and the block is ready again the next cycle.
// The output register lets the next item be taken while a sample waits.
// If the receiver stalls, the following tick waits in its last step until
// the output register frees, and tready stays low meanwhile.
// Reset clears the phase, the increment and both difference delays, and
// empties the output register.
module dpw_sawtooth_oscillator_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dpw_saw_pkg::FRAC_W-1:0]       cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [dpw_saw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] new_phase
  input  logic                                 s_axis_tuser,  // [0] command
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [dpw_saw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [33:0] sample_out, rest zero
);

  dpw_saw_pkg::cmd_t    cmd;
  dpw_saw_pkg::status_t status;
  logic signed [dpw_saw_pkg::SAMPLE_W-1:0] sample;
  logic                                    tick_acc;

  // Controller.
  dpw_saw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  dpw_saw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .new_phase_i (s_axis_tdata[dpw_saw_pkg::FRAC_W-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (sample)
  );

  assign m_axis_tdata = dpw_saw_pkg::OUT_TDATA_W'(unsigned'(sample));

  // A tick item is taken at this edge.
  assign tick_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == dpw_saw_pkg::CMD_TICK);

  // Checks on the controller and output register.
`include "dpw_sawtooth_oscillator_top_macros.svh"

  `DPW_SAW_ASSERT_SAME(a_commit_needs_room, cmd.commit, status.out_free, "commit while output full")
  `DPW_SAW_ASSERT_NEXT(a_tick_blocks_input, tick_acc, !s_axis_tready, "input taken during a tick")
  `DPW_SAW_ASSERT_NEXT(a_commit_shows_out, cmd.commit, m_axis_tvalid, "committed sample not shown")

endmodule
